/* rtl/core/dhwsu_pkg.sv */
// Shared types and constants for the detector hit word stream unpacker.
`default_nettype none

package dhwsu_pkg;

  // Result status codes
  localparam logic [1:0] STATUS_HIT       = 2'd0;
  localparam logic [1:0] STATUS_BAD_HDR   = 2'd1;
  localparam logic [1:0] STATUS_BAD_MAGIC = 2'd2;

  // Configuration register indexes
  localparam logic CFG_IDX_HDR_SIZE = 1'b0;
  localparam logic CFG_IDX_CH_CARD  = 1'b1;

  localparam int CFG_DATA_W = 9;
  localparam int OUT_DATA_W = 152;

  // Word patterns
  localparam logic [31:0] PAD_MASK     = 32'hfff0_0000;
  localparam logic [31:0] PAD_PATTERN  = 32'hadd0_0000;
  localparam logic [15:0] MAGIC_OLD    = 16'hAFFE;
  localparam logic [15:0] MAGIC_NEW    = 16'h115A;
  localparam logic [15:0] MAGIC_TOT    = 16'hBEEF;
  localparam logic [7:0]  META_CHANNEL = 8'hff;

  // Overflow word bits that feed the timing, energy and PID error flags
  localparam logic [23:0] TIMING_MASK = 24'h000601;
  localparam logic [23:0] ENERGY_MASK = 24'h00063e;
  localparam logic [23:0] PID_MASK    = 24'h00078e;

  localparam logic [8:0] RST_HDR_SIZE = 9'd52;
  localparam logic [8:0] RST_CH_CARD  = 9'd16;

  typedef struct packed {
    logic [1:0]         status;
    logic [15:0]        unit_id;
    logic [15:0]        energy;
    logic signed [15:0] fast_component;
    logic [15:0]        slow_component;
    logic [63:0]        time_stamp;
    logic [3:0]         error_flags;
    logic [15:0]        over_threshold_time;
    logic               over_threshold_present;
  } dhwsu_result_t;

endpackage

`default_nettype wire

/* rtl/core/dhwsu_parser.sv */
// Word-by-word buffer parser: phase register, event holds and result forming.
`default_nettype none

module dhwsu_parser (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           step,
  input  wire logic [31:0]                    word,
  input  wire logic                           last_word,
  input  wire logic                           cfg_wr_en,
  input  wire logic                           cfg_addr,
  input  wire logic [dhwsu_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output logic                                res_valid,
  output dhwsu_pkg::dhwsu_result_t            res
);
  import dhwsu_pkg::*;

  typedef enum logic [3:0] {
    PH_MODULE, PH_STAMP, PH_SUBHDR, PH_SIZE, PH_META,
    PH_EVENT, PH_TOT, PH_TRACE, PH_DISCARD
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [29:0] skip_r, skip_nxt;
  logic [63:0] stamp_r, stamp_nxt;
  logic [7:0]  card_r, card_nxt;
  logic [7:0]  chan_r, chan_nxt;
  logic [15:0] ev_r, ev_nxt;
  logic        newf_r, newf_nxt;
  logic [15:0] energy_r, energy_nxt;
  logic [31:0] shape_r, shape_nxt;
  logic [3:0]  flags_r, flags_nxt;
  logic [16:0] tot_r, tot_nxt;
  logic        hbad_r, hbad_nxt;
  logic [7:0]  hdr_size_r;
  logic [8:0]  ch_card_r;

  logic        is_pad;
  logic [13:0] quads;
  logic [13:0] rem;
  logic [23:0] ov;
  logic        emit_hit;
  logic        emit_err;
  logic [1:0]  err_code;
  logic [17:0] id_full;

  assign is_pad = (word & PAD_MASK) == PAD_PATTERN;
  assign quads  = ev_r[15:2];
  assign ov     = word[23:0];

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    skip_nxt   = skip_r;
    stamp_nxt  = stamp_r;
    card_nxt   = card_r;
    chan_nxt   = chan_r;
    ev_nxt     = ev_r;
    newf_nxt   = newf_r;
    energy_nxt = energy_r;
    shape_nxt  = shape_r;
    flags_nxt  = flags_r;
    tot_nxt    = tot_r;
    hbad_nxt   = hbad_r;
    emit_hit   = 1'b0;
    emit_err   = 1'b0;
    err_code   = STATUS_HIT;
    rem        = '0;

    unique case (phase_r)
      PH_MODULE: begin
        phase_nxt = PH_STAMP;
        pos_nxt   = '0;
        stamp_nxt = '0;
      end
      PH_STAMP: begin
        stamp_nxt[{pos_r[1:0], 4'b0000} +: 16] =
          stamp_r[{pos_r[1:0], 4'b0000} +: 16] | word[15:0];
        pos_nxt = pos_r + 4'd1;
        if (pos_r >= 4'd3) begin
          phase_nxt = PH_SUBHDR;
        end
      end
      PH_SUBHDR: begin
        if (!is_pad) begin
          hbad_nxt  = word[7:0] != hdr_size_r;
          card_nxt  = word[23:16];
          chan_nxt  = word[31:24];
          phase_nxt = PH_SIZE;
        end
      end
      PH_SIZE: begin
        if (hbad_r) begin
          phase_nxt = PH_DISCARD;
          emit_err  = 1'b1;
          err_code  = STATUS_BAD_HDR;
        end else if (word == 32'd0) begin
          phase_nxt = PH_SUBHDR;
        end else if (chan_r == META_CHANNEL) begin
          skip_nxt  = word[31:2];
          phase_nxt = (word[31:2] != 30'd0) ? PH_META : PH_SUBHDR;
        end else begin
          pos_nxt   = '0;
          phase_nxt = PH_EVENT;
        end
      end
      PH_META: begin
        skip_nxt = skip_r - 30'd1;
        if (skip_r == 30'd1) begin
          phase_nxt = PH_SUBHDR;
        end
      end
      PH_EVENT: begin
        pos_nxt = pos_r + 4'd1;
        if (pos_r == 4'd0) begin
          ev_nxt     = word[15:0];
          flags_nxt  = '0;
          tot_nxt    = '0;
          energy_nxt = '0;
          shape_nxt  = '0;
          if (word[31:16] == MAGIC_OLD) begin
            newf_nxt = 1'b0;
          end else if (word[31:16] == MAGIC_NEW) begin
            newf_nxt = 1'b1;
          end else begin
            phase_nxt = PH_DISCARD;
            emit_err  = 1'b1;
            err_code  = STATUS_BAD_MAGIC;
          end
        end else if (pos_r == 4'd6) begin
          flags_nxt = {1'b0, |(ov & PID_MASK), |(ov & ENERGY_MASK), |(ov & TIMING_MASK)};
        end else if (pos_r == 4'd7) begin
          if (word[15:0] != 16'd0) begin
            flags_nxt[3] = 1'b1;
          end
        end else if (pos_r == 4'd8) begin
          energy_nxt = word[15:0];
        end else if (!newf_r) begin
          if (pos_r == 4'd10) begin
            shape_nxt = word;
            phase_nxt = PH_SUBHDR;
            emit_hit  = 1'b1;
          end
        end else if (pos_r == 4'd9) begin
          shape_nxt = word;
          if (ev_r <= 16'd40) begin
            phase_nxt = PH_SUBHDR;
            emit_hit  = 1'b1;
          end
        end else if (pos_r == 4'd10) begin
          if (word[31:16] == MAGIC_TOT) begin
            tot_nxt   = {1'b1, word[15:0]};
            skip_nxt  = 30'd2;
            phase_nxt = PH_TOT;
          end else if (quads > 14'd10) begin
            rem = quads - 14'd11;
            if (rem == 14'd0) begin
              phase_nxt = PH_SUBHDR;
              emit_hit  = 1'b1;
            end else begin
              skip_nxt  = {16'd0, rem};
              phase_nxt = PH_TRACE;
            end
          end else begin
            // short event: this word already opens the next sub-header
            emit_hit  = 1'b1;
            phase_nxt = PH_SUBHDR;
            if (!is_pad) begin
              hbad_nxt  = word[7:0] != hdr_size_r;
              card_nxt  = word[23:16];
              chan_nxt  = word[31:24];
              phase_nxt = PH_SIZE;
            end
          end
        end
      end
      PH_TOT: begin
        skip_nxt = skip_r - 30'd1;
        if (skip_r == 30'd1) begin
          if (ev_r > 16'd52) begin
            rem = quads - 14'd13;
          end
          if (rem == 14'd0) begin
            phase_nxt = PH_SUBHDR;
            emit_hit  = 1'b1;
          end else begin
            skip_nxt  = {16'd0, rem};
            phase_nxt = PH_TRACE;
          end
        end
      end
      PH_TRACE: begin
        skip_nxt = skip_r - 30'd1;
        if (skip_r == 30'd1) begin
          phase_nxt = PH_SUBHDR;
          emit_hit  = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (last_word) begin
      phase_nxt = PH_MODULE;
      pos_nxt   = '0;
      skip_nxt  = '0;
    end
  end

  assign id_full   = 18'(card_r) * 18'(ch_card_r) + 18'(chan_r);
  assign res_valid = emit_hit | emit_err;

  always_comb begin
    res = '0;
    if (emit_err) begin
      res.status = err_code;
    end else begin
      res.status                 = STATUS_HIT;
      res.unit_id                = id_full[15:0];
      res.energy                 = energy_nxt;
      res.fast_component         = shape_nxt[15:0];
      res.slow_component         = shape_nxt[31:16];
      res.time_stamp             = stamp_nxt;
      res.error_flags            = flags_nxt;
      res.over_threshold_time    = tot_nxt[15:0];
      res.over_threshold_present = tot_nxt[16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_size_r <= RST_HDR_SIZE[7:0];
      ch_card_r  <= RST_CH_CARD;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_IDX_HDR_SIZE: hdr_size_r <= cfg_wdata[7:0];
        CFG_IDX_CH_CARD:  ch_card_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_MODULE;
      pos_r    <= '0;
      skip_r   <= '0;
      stamp_r  <= '0;
      card_r   <= '0;
      chan_r   <= '0;
      ev_r     <= '0;
      newf_r   <= 1'b0;
      energy_r <= '0;
      shape_r  <= '0;
      flags_r  <= '0;
      tot_r    <= '0;
      hbad_r   <= 1'b0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      skip_r   <= skip_nxt;
      stamp_r  <= stamp_nxt;
      card_r   <= card_nxt;
      chan_r   <= chan_nxt;
      ev_r     <= ev_nxt;
      newf_r   <= newf_nxt;
      energy_r <= energy_nxt;
      shape_r  <= shape_nxt;
      flags_r  <= flags_nxt;
      tot_r    <= tot_nxt;
      hbad_r   <= hbad_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/dhwsu_out_reg.sv */
// Result holding register with ready generation toward the input side.
`default_nettype none

module dhwsu_out_reg (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     load,
  input  wire dhwsu_pkg::dhwsu_result_t load_data,
  output logic                          take_ok,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output dhwsu_pkg::dhwsu_result_t      out_data
);
  import dhwsu_pkg::*;

  logic          valid_r;
  dhwsu_result_t data_r;

  // a new transaction may enter whenever the held result leaves this cycle
  assign take_ok   = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/detector_hit_word_stream_unpacker_top.sv */
// A result is registered and appears on out_ in the cycle after the word that completes it is taken.
// Throughput: one word per cycle while in_tready is high; the parse phase register is updated once per word.
// in_tready drops only while a held result waits on out_tready.
// Reset (rst_n low, synchronous): parser expects a module word, holds clear,
// configuration returns to header size 52 and 16 channels per card.
`default_nettype none

module detector_hit_word_stream_unpacker_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [31:0]                     in_tdata,   // [31:0] word
  input  wire logic                            in_tlast,   // last_word
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // [15:0] unit_id, [31:16] energy, [47:32] fast_component,
  // [63:48] slow_component, [127:64] time_stamp, [131:128] error_flags,
  // [147:132] over_threshold_time, [148] over_threshold_present, [151:149] zero
  output logic [dhwsu_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [1:0]                           out_tuser,  // [1:0] status
  input  wire logic                            cfg_wr_en,
  input  wire logic                            cfg_addr,
  input  wire logic [dhwsu_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import dhwsu_pkg::*;

  logic          step;
  logic          res_valid;
  dhwsu_result_t res;
  dhwsu_result_t held;

  assign step = in_tvalid && in_tready;

  dhwsu_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .word      (in_tdata),
    .last_word (in_tlast),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .res_valid (res_valid),
    .res       (res)
  );

  dhwsu_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step && res_valid),
    .load_data (res),
    .take_ok   (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (held)
  );

  assign out_tdata = {3'b000,
                      held.over_threshold_present,
                      held.over_threshold_time,
                      held.error_flags,
                      held.time_stamp,
                      held.slow_component,
                      held.fast_component,
                      held.energy,
                      held.unit_id};
  assign out_tuser = held.status;

endmodule

`default_nettype wire

/* rtl/core/dhwsu_checker.sv */
// Port-level checks for the unpacker top, attached by bind.
`default_nettype none

module dhwsu_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tvalid,
  input wire logic                             in_tready,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [dhwsu_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic [1:0]                       out_tuser
);
  import dhwsu_pkg::*;

  // a pending result must stay up until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  // with nothing held the input side is never stalled
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("in_tready low with empty output register");

  // a result only ever follows an input transaction
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready))
    else $error("out_tvalid rose without an input transaction");

  // error results carry nothing but the status code
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != STATUS_HIT |-> out_tdata == '0)
    else $error("error transaction carries payload");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == STATUS_HIT || out_tuser == STATUS_BAD_HDR ||
                   out_tuser == STATUS_BAD_MAGIC)
    else $error("undefined status code");

endmodule

bind detector_hit_word_stream_unpacker_top dhwsu_checker u_dhwsu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

/* tb/hit_stream_checker.sv */
// Checker: follows the accepted word stream, predicts unpacked hits and compares each result.
`timescale 1ns / 1ps

module hit_stream_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [31:0]                      in_tdata,   // [31:0] word
  input  logic                             in_tlast,   // last_word
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  // [15:0] unit_id, [31:16] energy, [47:32] fast_component,
  // [63:48] slow_component, [127:64] time_stamp, [131:128] error_flags,
  // [147:132] over_threshold_time, [148] over_threshold_present
  input  logic [dhwsu_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic [1:0]                       out_tuser,  // [1:0] status
  input  logic                             cfg_wr_en,
  input  logic                             cfg_addr,
  input  logic [dhwsu_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                               mismatch_count,
  output int                               hits_outstanding
);
  import dhwsu_pkg::*;

  typedef enum logic [3:0] {
    SEEK_MODULE, TAKE_STAMP, SEEK_HEADER, TAKE_SIZE, SKIP_META,
    IN_EVENT, SKIP_TOT, SKIP_TRACE, DROP_BUFFER
  } parse_state_t;

  parse_state_t   state;
  logic [13:0]    word_idx;
  logic [29:0]    skip_cnt;
  logic [63:0]    stamp;
  logic [7:0]     card;
  logic [7:0]     chan;
  logic [15:0]    ev_size;
  logic           is_new;
  logic [15:0]    energy;
  logic [31:0]    shape;
  logic [3:0]     flags;
  logic [16:0]    tot;
  logic           hdr_mismatch;
  logic [7:0]     hdr_size_cfg;
  logic [8:0]     ch_per_card_cfg;

  dhwsu_result_t  pending_hits[$];
  dhwsu_result_t  want;
  int             errors = 0;

  function automatic dhwsu_result_t hit_result();
    dhwsu_result_t r;
    logic [31:0]   id;
    id = card * ch_per_card_cfg + chan;
    r.status                 = STATUS_HIT;
    r.unit_id                = id[15:0];
    r.energy                 = energy;
    r.fast_component         = shape[15:0];
    r.slow_component         = shape[31:16];
    r.time_stamp             = stamp;
    r.error_flags            = flags;
    r.over_threshold_time    = tot[15:0];
    r.over_threshold_present = tot[16];
    return r;
  endfunction

  function automatic dhwsu_result_t error_result(input logic [1:0] code);
    dhwsu_result_t r;
    r = '0;
    r.status = code;
    return r;
  endfunction

  task automatic take_header(input logic [31:0] w);
    if ((w & PAD_MASK) != PAD_PATTERN) begin
      hdr_mismatch = (w[7:0] != hdr_size_cfg);
      card = w[23:16];
      chan = w[31:24];
      state = TAKE_SIZE;
    end
  endtask

  task automatic trace_or_hit(input logic [29:0] rem);
    if (rem == 0) begin
      state = SEEK_HEADER;
      pending_hits.push_back(hit_result());
    end else begin
      skip_cnt = rem;
      state = SKIP_TRACE;
    end
  endtask

  task automatic event_word(input logic [31:0] w);
    logic [13:0] idx;
    logic [23:0] ov;
    idx = word_idx;
    word_idx = word_idx + 14'd1;
    if (idx == 0) begin
      ev_size = w[15:0];
      flags = '0;
      tot = '0;
      energy = '0;
      shape = '0;
      if (w[31:16] == MAGIC_OLD) begin
        is_new = 1'b0;
      end else if (w[31:16] == MAGIC_NEW) begin
        is_new = 1'b1;
      end else begin
        state = DROP_BUFFER;
        pending_hits.push_back(error_result(STATUS_BAD_MAGIC));
      end
    end else if (idx == 6) begin
      ov = w[23:0];
      flags = {1'b0, |(ov & PID_MASK), |(ov & ENERGY_MASK), |(ov & TIMING_MASK)};
    end else if (idx == 7) begin
      if (w[15:0] != 0) flags[3] = 1'b1;
    end else if (idx == 8) begin
      energy = w[15:0];
    end else if (!is_new) begin
      if (idx == 10) begin
        shape = w;
        state = SEEK_HEADER;
        pending_hits.push_back(hit_result());
      end
    end else if (idx == 9) begin
      shape = w;
      if (ev_size <= 40) begin
        state = SEEK_HEADER;
        pending_hits.push_back(hit_result());
      end
    end else if (idx == 10) begin
      if (w[31:16] == MAGIC_TOT) begin
        tot = {1'b1, w[15:0]};
        skip_cnt = 30'd2;
        state = SKIP_TOT;
      end else if (ev_size[15:2] > 10) begin
        trace_or_hit(ev_size[15:2] - 14'd11);
      end else begin
        // short event: this word already belongs to the next sub-header
        state = SEEK_HEADER;
        pending_hits.push_back(hit_result());
        take_header(w);
      end
    end
  endtask

  task automatic parse_word(input logic [31:0] w, input logic last_w);
    case (state)
      SEEK_MODULE: begin
        state = TAKE_STAMP;
        word_idx = '0;
        stamp = '0;
      end
      TAKE_STAMP: begin
        stamp = stamp | ({48'b0, w[15:0]} << (word_idx[1:0] * 16));
        word_idx = word_idx + 14'd1;
        if (word_idx >= 4) state = SEEK_HEADER;
      end
      SEEK_HEADER: take_header(w);
      TAKE_SIZE: begin
        if (hdr_mismatch) begin
          state = DROP_BUFFER;
          pending_hits.push_back(error_result(STATUS_BAD_HDR));
        end else if (w == 0) begin
          state = SEEK_HEADER;
        end else if (chan == META_CHANNEL) begin
          skip_cnt = w[31:2];
          state = (skip_cnt != 0) ? SKIP_META : SEEK_HEADER;
        end else begin
          word_idx = '0;
          state = IN_EVENT;
        end
      end
      SKIP_META: begin
        skip_cnt = skip_cnt - 30'd1;
        if (skip_cnt == 0) state = SEEK_HEADER;
      end
      IN_EVENT: event_word(w);
      SKIP_TOT: begin
        skip_cnt = skip_cnt - 30'd1;
        if (skip_cnt == 0) begin
          if (ev_size > 52) trace_or_hit(ev_size[15:2] - 14'd13);
          else trace_or_hit('0);
        end
      end
      SKIP_TRACE: begin
        skip_cnt = skip_cnt - 30'd1;
        if (skip_cnt == 0) begin
          state = SEEK_HEADER;
          pending_hits.push_back(hit_result());
        end
      end
      default: ;
    endcase
    // a truncated buffer drops whatever was in progress
    if (last_w) begin
      state = SEEK_MODULE;
      word_idx = '0;
      skip_cnt = '0;
    end
  endtask

  function automatic void check_field(input string name, input logic [63:0] want_v,
                                      input logic [63:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      state           = SEEK_MODULE;
      word_idx        = '0;
      skip_cnt        = '0;
      stamp           = '0;
      card            = '0;
      chan            = '0;
      ev_size         = '0;
      is_new          = 1'b0;
      energy          = '0;
      shape           = '0;
      flags           = '0;
      tot             = '0;
      hdr_mismatch    = 1'b0;
      hdr_size_cfg    = RST_HDR_SIZE[7:0];
      ch_per_card_cfg = RST_CH_CARD;
      pending_hits.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_hits.size() == 0) begin
          $error("result transaction with no hit pending: %0h %0h", out_tuser, out_tdata);
          errors++;
        end else begin
          want = pending_hits.pop_front();
          check_field("status", want.status, out_tuser);
          check_field("unit_id", want.unit_id, out_tdata[15:0]);
          check_field("energy", want.energy, out_tdata[31:16]);
          check_field("fast_component", $unsigned(want.fast_component), out_tdata[47:32]);
          check_field("slow_component", want.slow_component, out_tdata[63:48]);
          check_field("time_stamp", want.time_stamp, out_tdata[127:64]);
          check_field("error_flags", want.error_flags, out_tdata[131:128]);
          check_field("over_threshold_time", want.over_threshold_time, out_tdata[147:132]);
          check_field("over_threshold_present", want.over_threshold_present,
                      out_tdata[148]);
        end
      end
      if (cfg_wr_en) begin
        if (cfg_addr == CFG_IDX_HDR_SIZE) hdr_size_cfg = cfg_wdata[7:0];
        else ch_per_card_cfg = cfg_wdata;
      end
      if (in_tvalid && in_tready) parse_word(in_tdata, in_tlast);
    end
    mismatch_count   <= errors;
    hits_outstanding <= pending_hits.size();
  end

endmodule

/* tb/detector_hit_word_stream_unpacker_top_tb.sv */
// Testbench top: feeds readout buffers and register settings to the unpacker, gives the verdict.
`timescale 1ns / 1ps

module detector_hit_word_stream_unpacker_top_tb;
  import dhwsu_pkg::*;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [31:0]           in_tdata   = '0;  // [31:0] word
  logic                  in_tlast   = 1'b0; // last_word
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [15:0] unit_id, [31:16] energy, [47:32] fast_component,
  // [63:48] slow_component, [127:64] time_stamp, [131:128] error_flags,
  // [147:132] over_threshold_time, [148] over_threshold_present, [151:149] zero
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;  // [1:0] status
  logic                  cfg_wr_en  = 1'b0;
  logic                  cfg_addr   = CFG_IDX_HDR_SIZE;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  int                    mismatch_count;
  int                    hits_outstanding;

  int                    send_idle_pct = 0;
  int                    recv_idle_pct = 0;
  int                    items_sent    = 0;
  logic [7:0]            cur_hdr       = RST_HDR_SIZE[7:0];
  bit                    open_event;
  logic [31:0]           word_buf[$];

  detector_hit_word_stream_unpacker_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  hit_stream_checker u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .in_tlast         (in_tlast),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .out_tuser        (out_tuser),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .mismatch_count   (mismatch_count),
    .hits_outstanding (hits_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic logic [15:0] rnd16();
    logic [15:0] v;
    v = 16'($urandom);
    return v;
  endfunction

  function automatic logic [31:0] pad_word();
    return PAD_PATTERN | ($urandom & ~PAD_MASK);
  endfunction

  // event words 1..9: overflow at 6, pileup at 7, energy at 8, new-format shape at 9
  function automatic void add_body();
    logic [31:0] ov;
    repeat (5) word_buf.push_back($urandom);
    case ($urandom_range(3))
      0:       ov = '0;
      1:       ov = $urandom;
      2:       ov = 32'h1 << $urandom_range(23);
      default: ov = $urandom & $urandom & $urandom;
    endcase
    word_buf.push_back(ov);
    word_buf.push_back($urandom_range(1) ? ($urandom & 32'hFFFF_0000) : $urandom);
    word_buf.push_back($urandom);
    word_buf.push_back($urandom);
  endfunction

  // returns 1 when the rest of the buffer is to be cut off
  function automatic bit add_event();
    logic [15:0] magic;
    logic [15:0] ev_size;
    logic [31:0] w;
    int          sel;
    int          ntrace;
    sel = $urandom_range(9);
    if (sel == 0) begin
      magic = 16'($urandom);
      if (magic == MAGIC_OLD || magic == MAGIC_NEW) magic = ~magic;
      word_buf.push_back({magic, rnd16()});
      repeat ($urandom_range(3)) word_buf.push_back($urandom);
      return 1'b1;
    end
    if (sel <= 3) begin
      word_buf.push_back({MAGIC_OLD, rnd16()});
      add_body();
      word_buf.push_back($urandom);
      return 1'b0;
    end
    case ($urandom_range(5))
      0:       ev_size = 16'($urandom_range(40));
      1:       ev_size = 16'($urandom_range(43, 41));
      2:       ev_size = 16'($urandom_range(60, 44));
      3:       ev_size = 16'($urandom_range(120, 41));
      4:       ev_size = 16'($urandom_range(120, 53));
      default: ev_size = rnd16();
    endcase
    word_buf.push_back({MAGIC_NEW, ev_size});
    add_body();
    if (ev_size <= 40) return 1'b0;
    ntrace = 0;
    if ($urandom_range(1)) begin
      word_buf.push_back({MAGIC_TOT, rnd16()});
      repeat (2) word_buf.push_back($urandom);
      if (ev_size > 52) ntrace = (ev_size >> 2) - 13;
    end else if (ev_size < 44) begin
      // hit completes on the next sub-header word
      open_event = 1'b1;
    end else begin
      w = $urandom;
      if (w[31:16] == MAGIC_TOT) w = w ^ 32'h8000_0000;
      word_buf.push_back(w);
      ntrace = (ev_size >> 2) - 11;
    end
    if (ntrace > 40) begin
      repeat ($urandom_range(20)) word_buf.push_back($urandom);
      return 1'b1;
    end
    repeat (ntrace) word_buf.push_back($urandom);
    return 1'b0;
  endfunction

  function automatic bit add_channel();
    logic [7:0]  chan;
    logic [7:0]  card;
    logic [7:0]  spare;
    logic [7:0]  size_byte;
    logic [31:0] size_w;
    int          n;
    open_event = 1'b0;
    if ($urandom_range(3) == 0) repeat ($urandom_range(2, 1)) word_buf.push_back(pad_word());
    card  = 8'($urandom);
    spare = 8'($urandom);
    chan  = ($urandom_range(6) == 0) ? META_CHANNEL : 8'($urandom);
    size_byte = ($urandom_range(19) == 0) ? 8'($urandom) : cur_hdr;
    word_buf.push_back({chan, card, spare, size_byte});
    if (size_byte != cur_hdr) begin
      word_buf.push_back($urandom);
      repeat ($urandom_range(3)) word_buf.push_back($urandom);
      return 1'b1;
    end
    if ($urandom_range(9) == 0) begin
      word_buf.push_back('0);
      return 1'b0;
    end
    if (chan == META_CHANNEL) begin
      if ($urandom_range(9) == 0) begin
        // metadata far longer than the buffer: cut off mid-skip
        word_buf.push_back($urandom | 32'h8000_0000);
        repeat ($urandom_range(3)) word_buf.push_back($urandom);
        return 1'b1;
      end
      n = $urandom_range(4);
      size_w = (n << 2) | $urandom_range(3);
      if (size_w == 0) size_w = 32'd3;
      word_buf.push_back(size_w);
      repeat (n) word_buf.push_back($urandom);
      return 1'b0;
    end
    size_w = $urandom;
    if (size_w == 0) size_w = 32'd1;
    word_buf.push_back(size_w);
    return add_event();
  endfunction

  function automatic void build_buffer();
    bit stop;
    int keep;
    word_buf.delete();
    open_event = 1'b0;
    stop = 1'b0;
    repeat (5) word_buf.push_back($urandom);  // module word and four stamp words
    repeat ($urandom_range(4, 1)) if (!stop) stop = add_channel();
    if (!stop && (open_event || $urandom_range(2) == 0)) word_buf.push_back(pad_word());
    if ($urandom_range(7) == 0) begin
      keep = $urandom_range(word_buf.size() - 1, 1);
      word_buf = word_buf[0:keep-1];
    end
  endfunction

  function automatic void build_noise();
    word_buf.delete();
    repeat ($urandom_range(12, 1)) word_buf.push_back($urandom);
  endfunction

  task automatic push_word(input logic [31:0] w, input logic last_w);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    in_tlast  <= last_w;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_buffer();
    int i;
    for (i = 0; i < word_buf.size(); i++) push_word(word_buf[i], i == word_buf.size() - 1);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (hits_outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // back-to-back writes keep the enable high; caller lowers it
  task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == CFG_IDX_HDR_SIZE) cur_hdr = val[7:0];
  endtask

  initial begin
    int ph;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    for (ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        wait_drained();
        case (ph)
          1: begin
            write_reg(CFG_IDX_HDR_SIZE, 9'd0);
            write_reg(CFG_IDX_CH_CARD, 9'd1);
          end
          2: begin
            write_reg(CFG_IDX_HDR_SIZE, 9'd255);
            write_reg(CFG_IDX_CH_CARD, 9'd256);
          end
          3: begin
            write_reg(CFG_IDX_HDR_SIZE, 9'h134);
            write_reg(CFG_IDX_CH_CARD, 9'h1FF);
          end
          4: begin
            write_reg(CFG_IDX_HDR_SIZE, 9'($urandom_range(255)));
            write_reg(CFG_IDX_CH_CARD, 9'd0);
          end
          default: begin
            write_reg(CFG_IDX_HDR_SIZE, 9'($urandom_range(255)));
            write_reg(CFG_IDX_CH_CARD, 9'($urandom_range(256, 1)));
          end
        endcase
        cfg_wr_en <= 1'b0;
      end
      case (ph % 3)
        0: begin
          send_idle_pct = 12;
          recv_idle_pct = 67;
        end
        1: begin
          send_idle_pct = 67;
          recv_idle_pct = 12;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (ph == 0) begin
        // all-ones stamp, padding, empty and metadata channels, then unknown magic
        word_buf = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 32'hADDF_FFFF, {24'h00_0000, cur_hdr}, 32'h0000_0000,
                     {24'hFF_FFFF, cur_hdr}, 32'h0000_0007, 32'h0000_0000,
                     {24'h01_0200, cur_hdr}, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        send_buffer();
        // wrong header size, reported on the last word
        word_buf = '{32'h0000_0000, 32'h0000_FFFF, 32'h0000_0000, 32'h1234_5678,
                     32'h0000_0000, {24'h0304_FF, ~cur_hdr}, 32'h0000_0010};
        send_buffer();
      end
      while (items_sent < (ph + 1) * 325) begin
        if ($urandom_range(11) == 0) build_noise();
        else build_buffer();
        send_buffer();
      end
    end
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && hits_outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* detector_hit_word_stream_unpacker_top.f */
rtl/core/dhwsu_pkg.sv
rtl/core/dhwsu_parser.sv
rtl/core/dhwsu_out_reg.sv
rtl/core/detector_hit_word_stream_unpacker_top.sv
rtl/core/dhwsu_checker.sv
tb/hit_stream_checker.sv
tb/detector_hit_word_stream_unpacker_top_tb.sv
